>>> sv/skp_pkg.sv
// shared constants and codes for the sorted key page
package skp_pkg;

  localparam int MAX_KEYS = 7;
  localparam int KEY_W    = 32;
  localparam int REC_W    = 31;
  localparam int FLD_W    = 3;
  localparam int CNT_W    = $clog2(MAX_KEYS + 1);
  localparam int IDX_W    = $clog2(MAX_KEYS);

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_SEARCH = 2'd1;
  localparam logic [1:0] OP_POP    = 2'd2;
  localparam logic [1:0] OP_SPLIT  = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_FULL      = 3'd1;
  localparam logic [2:0] ST_FOUND     = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_EMPTY     = 3'd4;

  typedef struct packed {
    logic                    en;
    logic [IDX_W-1:0]        idx;
    logic signed [KEY_W-1:0] key;
    logic [REC_W-1:0]        rec;
  } store_wr_t;

endpackage

>>> sv/skp_ifs.sv
// request and result channel interfaces
interface skp_req_if;
  import skp_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [1:0]              op;
  logic signed [KEY_W-1:0] item_key;
  logic [REC_W-1:0]        record_number;
  modport source (output valid, output op, output item_key, output record_number,
                  input ready);
  modport sink (input valid, input op, input item_key, input record_number,
                output ready);
endinterface

interface skp_rsp_if;
  import skp_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [2:0]              status;
  logic [FLD_W-1:0]        position;
  logic signed [KEY_W-1:0] out_key;
  logic [REC_W-1:0]        out_record;
  logic [FLD_W-1:0]        entry_count;
  logic                    last;
  modport source (output valid, output status, output position, output out_key,
                  output out_record, output entry_count, output last, input ready);
  modport sink (input valid, input status, input position, input out_key,
                input out_record, input entry_count, input last, output ready);
endinterface

>>> sv/skp_store.sv
// key and record register file, one write and one read port
module skp_store (
  input  logic                             clk,
  input  skp_pkg::store_wr_t               wr,
  input  logic [skp_pkg::IDX_W-1:0]        rd_idx,
  output logic signed [skp_pkg::KEY_W-1:0] rd_key,
  output logic [skp_pkg::REC_W-1:0]        rd_rec
);
  import skp_pkg::*;

  logic signed [KEY_W-1:0] keys [MAX_KEYS];
  logic [REC_W-1:0]        recs [MAX_KEYS];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      keys[wr.idx] <= wr.key;
      recs[wr.idx] <= wr.rec;
    end
  end

  assign rd_key = keys[rd_idx];
  assign rd_rec = recs[rd_idx];

endmodule

>>> sv/sorted_key_page.sv
// Sorted key page: holds up to MAX_KEYS (key, record) pairs in ascending signed key order
// and runs insert, search, pop-smallest and split on them. One operation is in flight at a
// time; req.ready is high only while the sequencer is idle. After the accepting beat an
// insert moves every stored pair with a key greater than the new key up one slot and then
// writes the new pair (it reports full at once on a full page), a search probes the middle
// of the remaining range until it finds the key or the range is empty, a pop reads the
// smallest pair and moves each remaining pair down one slot, and a split emits the upper
// half of the pairs one by one (an empty status on an empty page). The sequencer then
// returns to idle before it takes the next request. The steps share the single read port
// of the pair store; a step also waits while the result register is occupied.
module sorted_key_page (
  input  logic clk,
  input  logic rst,
  skp_req_if.sink   req,
  skp_rsp_if.source rsp
);
  import skp_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_INS   = 5'b00010,
    S_SRCH  = 5'b00100,
    S_POP   = 5'b01000,
    S_SPLIT = 5'b10000
  } state_t;

  state_t                  state, state_next;
  logic [CNT_W-1:0]        count, count_next;
  logic [CNT_W-1:0]        p, p_next;
  logic signed [CNT_W:0]   l, l_next, r, r_next;
  logic signed [KEY_W-1:0] op_key;
  logic [REC_W-1:0]        op_rec;
  logic signed [KEY_W-1:0] hold_key, hold_key_next;
  logic [REC_W-1:0]        hold_rec, hold_rec_next;

  logic                    out_valid;
  logic [2:0]              out_status;
  logic [FLD_W-1:0]        out_pos, out_cnt;
  logic signed [KEY_W-1:0] out_key;
  logic [REC_W-1:0]        out_rec;
  logic                    out_last;

  logic                    emit;
  logic [2:0]              e_status;
  logic [CNT_W-1:0]        e_pos, e_cnt;
  logic signed [KEY_W-1:0] e_key;
  logic [REC_W-1:0]        e_rec;
  logic                    e_last;

  store_wr_t               wr;
  logic [CNT_W-1:0]        rd_addr;
  logic signed [KEY_W-1:0] rd_key;
  logic [REC_W-1:0]        rd_rec;
  logic signed [CNT_W:0]   mid;
  logic [CNT_W-1:0]        keep;
  logic                    slot_free, accept;

  skp_store u_store (
    .clk    (clk),
    .wr     (wr),
    .rd_idx (rd_addr[IDX_W-1:0]),
    .rd_key (rd_key),
    .rd_rec (rd_rec)
  );

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign slot_free = !out_valid || rsp.ready;
  assign mid       = l + ((r - l) >>> 1);
  assign keep      = count >> 1;

  always_comb begin
    unique case (state)
      S_INS:   rd_addr = p - CNT_W'(1);
      S_SRCH:  rd_addr = mid[CNT_W-1:0];
      default: rd_addr = p;
    endcase
  end

  always_comb begin
    state_next    = state;
    count_next    = count;
    p_next        = p;
    l_next        = l;
    r_next        = r;
    hold_key_next = hold_key;
    hold_rec_next = hold_rec;
    wr            = '0;
    emit          = 1'b0;
    e_status      = ST_OK;
    e_pos         = '0;
    e_cnt         = count;
    e_key         = '0;
    e_rec         = '0;
    e_last        = 1'b1;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          l_next = '0;
          r_next = $signed({1'b0, count}) - (CNT_W+1)'(1);
          unique case (req.op)
            OP_INSERT: begin
              state_next = S_INS;
              p_next     = count;
            end
            OP_SEARCH: state_next = S_SRCH;
            OP_POP: begin
              state_next = S_POP;
              p_next     = '0;
            end
            default: begin
              state_next = S_SPLIT;
              p_next     = count >> 1;
            end
          endcase
        end
      end
      S_INS: begin
        if (slot_free) begin
          if (count >= CNT_W'(MAX_KEYS)) begin
            emit       = 1'b1;
            e_status   = ST_FULL;
            state_next = S_IDLE;
          end else if (p != '0 && rd_key > op_key) begin
            // move the larger pair up one slot
            wr.en  = 1'b1;
            wr.idx = p[IDX_W-1:0];
            wr.key = rd_key;
            wr.rec = rd_rec;
            p_next = p - CNT_W'(1);
          end else begin
            wr.en      = 1'b1;
            wr.idx     = p[IDX_W-1:0];
            wr.key     = op_key;
            wr.rec     = op_rec;
            count_next = count + CNT_W'(1);
            emit       = 1'b1;
            e_pos      = p;
            e_cnt      = count + CNT_W'(1);
            state_next = S_IDLE;
          end
        end
      end
      S_SRCH: begin
        if (slot_free) begin
          if (r < l) begin
            emit       = 1'b1;
            e_status   = ST_NOT_FOUND;
            e_pos      = l[CNT_W-1:0];
            state_next = S_IDLE;
          end else if (rd_key == op_key) begin
            emit       = 1'b1;
            e_status   = ST_FOUND;
            e_pos      = mid[CNT_W-1:0];
            state_next = S_IDLE;
          end else if (rd_key > op_key) begin
            r_next = mid - (CNT_W+1)'(1);
          end else begin
            l_next = mid + (CNT_W+1)'(1);
          end
        end
      end
      S_POP: begin
        if (slot_free) begin
          if (count == '0) begin
            emit       = 1'b1;
            e_status   = ST_EMPTY;
            state_next = S_IDLE;
          end else if (p == '0) begin
            hold_key_next = rd_key;
            hold_rec_next = rd_rec;
            p_next        = CNT_W'(1);
          end else if (p < count) begin
            // close the gap left by the smallest pair
            wr.en  = 1'b1;
            wr.idx = IDX_W'(p - CNT_W'(1));
            wr.key = rd_key;
            wr.rec = rd_rec;
            p_next = p + CNT_W'(1);
          end else begin
            count_next = count - CNT_W'(1);
            emit       = 1'b1;
            e_key      = hold_key;
            e_rec      = hold_rec;
            e_cnt      = count - CNT_W'(1);
            state_next = S_IDLE;
          end
        end
      end
      S_SPLIT: begin
        if (slot_free) begin
          if (count == '0) begin
            emit       = 1'b1;
            e_status   = ST_EMPTY;
            state_next = S_IDLE;
          end else begin
            emit   = 1'b1;
            e_pos  = p - keep;
            e_key  = rd_key;
            e_rec  = rd_rec;
            e_cnt  = keep;
            e_last = (p + CNT_W'(1) == count);
            p_next = p + CNT_W'(1);
            if (p + CNT_W'(1) == count) begin
              count_next = keep;
              state_next = S_IDLE;
            end
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    p        <= p_next;
    l        <= l_next;
    r        <= r_next;
    hold_key <= hold_key_next;
    hold_rec <= hold_rec_next;
    if (accept) begin
      op_key <= req.item_key;
      op_rec <= req.record_number;
    end
    if (emit) begin
      out_status <= e_status;
      out_pos    <= FLD_W'(e_pos);
      out_key    <= e_key;
      out_rec    <= e_rec;
      out_cnt    <= FLD_W'(e_cnt);
      out_last   <= e_last;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.position    = out_pos;
  assign rsp.out_key     = out_key;
  assign rsp.out_record  = out_rec;
  assign rsp.entry_count = out_cnt;
  assign rsp.last        = out_last;

endmodule

>>> sv/skp_checker.sv
// port-level checks for the sorted key page, bound to the top level
module skp_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             req_valid,
  input logic                             req_ready,
  input logic                             rsp_valid,
  input logic                             rsp_ready,
  input logic [2:0]                       rsp_status,
  input logic [skp_pkg::FLD_W-1:0]        rsp_entry_count,
  input logic signed [skp_pkg::KEY_W-1:0] rsp_key,
  input logic                             rsp_last
);
  import skp_pkg::*;

  // a stalled result beat holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_key) && $stable(rsp_status))
    else $error("result beat changed while stalled");

  // one operation at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while an operation is running");

  // every result with a status other than ok is a closing beat
  a_single_last: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_status == ST_FULL || rsp_status == ST_FOUND ||
                  rsp_status == ST_NOT_FOUND || rsp_status == ST_EMPTY) |-> rsp_last)
    else $error("non-ok result without last");

  // a rejected insert only happens on a full page
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status == ST_FULL |-> rsp_entry_count == FLD_W'(MAX_KEYS))
    else $error("full status with page not full");

endmodule

bind sorted_key_page skp_checker u_skp_checker (
  .clk             (clk),
  .rst             (rst),
  .req_valid       (req.valid),
  .req_ready       (req.ready),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .rsp_status      (rsp.status),
  .rsp_entry_count (rsp.entry_count),
  .rsp_key         (rsp.out_key),
  .rsp_last        (rsp.last)
);

>>> tb/sv/sorted_key_page_checker.sv
`timescale 1ns / 1ps
// scoreboard for the sorted key page: mirrors the page contents and checks every result beat
module sorted_key_page_checker (
  input  logic clk,
  input  logic rst,
  skp_req_if   req,
  skp_rsp_if   rsp,
  output int   err_count,
  output int   pending,
  output int   beats_checked,
  output int   n_insert,
  output int   n_search,
  output int   n_pop,
  output int   n_split
);
  import skp_pkg::*;

  localparam int REPORT_MAX = 10;

  typedef struct packed {
    logic [2:0]              status;
    logic [FLD_W-1:0]        position;
    logic signed [KEY_W-1:0] key;
    logic [REC_W-1:0]        rec;
    logic [FLD_W-1:0]        cnt;
    logic                    last;
  } page_result_t;

  page_result_t            due_results[$];
  logic signed [KEY_W-1:0] page_keys [MAX_KEYS];
  logic [REC_W-1:0]        page_recs [MAX_KEYS];
  int                      page_count;

  function automatic void queue_result(input logic [2:0] st, input int pos,
                                       input logic signed [KEY_W-1:0] k,
                                       input logic [REC_W-1:0] r, input int cnt,
                                       input logic lst);
    page_result_t res;
    res.status   = st;
    res.position = pos[FLD_W-1:0];
    res.key      = k;
    res.rec      = r;
    res.cnt      = cnt[FLD_W-1:0];
    res.last     = lst;
    due_results.push_back(res);
  endfunction

  // updates the mirrored page and queues the result beats one request causes
  function automatic void apply_page_op(input logic [1:0] op,
                                        input logic signed [KEY_W-1:0] key,
                                        input logic [REC_W-1:0] rec);
    int p;
    int lo;
    int hi;
    int mid;
    int keep;
    logic signed [KEY_W-1:0] k0;
    logic [REC_W-1:0] r0;
    case (op)
      OP_INSERT: begin
        n_insert++;
        if (page_count >= MAX_KEYS) begin
          queue_result(ST_FULL, 0, '0, '0, page_count, 1'b1);
        end else begin
          // new pair lands after any equal keys
          p = page_count;
          while (p > 0 && page_keys[p-1] > key) begin
            page_keys[p] = page_keys[p-1];
            page_recs[p] = page_recs[p-1];
            p--;
          end
          page_keys[p] = key;
          page_recs[p] = rec;
          page_count++;
          queue_result(ST_OK, p, '0, '0, page_count, 1'b1);
        end
      end
      OP_SEARCH: begin
        n_search++;
        lo = 0;
        hi = page_count - 1;
        while (hi >= lo) begin
          mid = lo + (hi - lo) / 2;
          if (page_keys[mid] == key) begin
            queue_result(ST_FOUND, mid, '0, '0, page_count, 1'b1);
            return;
          end
          if (page_keys[mid] > key) hi = mid - 1;
          else lo = mid + 1;
        end
        queue_result(ST_NOT_FOUND, lo, '0, '0, page_count, 1'b1);
      end
      OP_POP: begin
        n_pop++;
        if (page_count == 0) begin
          queue_result(ST_EMPTY, 0, '0, '0, 0, 1'b1);
        end else begin
          k0 = page_keys[0];
          r0 = page_recs[0];
          for (int i = 1; i < page_count; i++) begin
            page_keys[i-1] = page_keys[i];
            page_recs[i-1] = page_recs[i];
          end
          page_count--;
          queue_result(ST_OK, 0, k0, r0, page_count, 1'b1);
        end
      end
      default: begin
        n_split++;
        if (page_count == 0) begin
          queue_result(ST_EMPTY, 0, '0, '0, 0, 1'b1);
        end else begin
          keep = page_count / 2;
          for (int i = keep; i < page_count; i++)
            queue_result(ST_OK, i - keep, page_keys[i], page_recs[i], keep,
                         i == page_count - 1);
          page_count = keep;
        end
      end
    endcase
  endfunction

  task automatic note_mismatch(input string what, input page_result_t want,
                               input page_result_t got);
    err_count++;
    if (err_count <= REPORT_MAX) begin
      $display("%0t: %s", $time, what);
      $display("  expected status %0d pos %0d key %0d rec %0d count %0d last %0d",
               want.status, want.position, want.key, want.rec, want.cnt, want.last);
      $display("  actual   status %0d pos %0d key %0d rec %0d count %0d last %0d",
               got.status, got.position, got.key, got.rec, got.cnt, got.last);
    end
  endtask

  always @(posedge clk) begin : watch
    page_result_t got;
    page_result_t want;
    if (rst) begin
      due_results.delete();
      page_count    = 0;
      err_count     = 0;
      beats_checked = 0;
      n_insert      = 0;
      n_search      = 0;
      n_pop         = 0;
      n_split       = 0;
    end else begin
      if (req.valid && req.ready)
        apply_page_op(req.op, req.item_key, req.record_number);
      if (rsp.valid && rsp.ready) begin
        got.status   = rsp.status;
        got.position = rsp.position;
        got.key      = rsp.out_key;
        got.rec      = rsp.out_record;
        got.cnt      = rsp.entry_count;
        got.last     = rsp.last;
        beats_checked++;
        if (due_results.size() == 0) begin
          note_mismatch("result beat with nothing outstanding", '0, got);
        end else begin
          want = due_results.pop_front();
          if (got.status !== want.status || got.position !== want.position ||
              got.key !== want.key || got.rec !== want.rec ||
              got.cnt !== want.cnt || got.last !== want.last)
            note_mismatch("result beat mismatch", want, got);
        end
      end
    end
    pending = due_results.size();
  end

endmodule

>>> tb/sv/sorted_key_page_tb.sv
`timescale 1ns / 1ps
// top of the sorted key page testbench: clock, reset, request stimulus and verdict
module sorted_key_page_tb;
  import skp_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int LONG_HOLD    = 400;
  localparam int SEGMENTS     = 9;
  localparam int SEG_ITEMS    = 50;
  localparam int TAIL_CYCLES  = 20;
  localparam logic signed [KEY_W-1:0] KEY_LO = 32'sh8000_0000;
  localparam logic signed [KEY_W-1:0] KEY_HI = 32'sh7fff_ffff;
  localparam logic [REC_W-1:0]        REC_HI = '1;

  logic clk;
  logic rst;
  int   cyc = 0;
  int   err_count;
  int   pending;
  int   beats_checked;
  int   n_insert;
  int   n_search;
  int   n_pop;
  int   n_split;
  bit   tx_steady;

  skp_req_if req_ch ();
  skp_rsp_if rsp_ch ();

  sorted_key_page i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  sorted_key_page_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .req           (req_ch),
    .rsp           (rsp_ch),
    .err_count     (err_count),
    .pending       (pending),
    .beats_checked (beats_checked),
    .n_insert      (n_insert),
    .n_search      (n_search),
    .n_pop         (n_pop),
    .n_split       (n_split)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // result side: short random stalls, quiet windows, and one long hold-off
  initial begin : rsp_side
    int   stall_left;
    int   rx_cyc;
    int   r;
    bit   held;
    logic nxt;
    stall_left   = 0;
    rx_cyc       = 0;
    held         = 1'b0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      rx_cyc++;
      if (!held && beats_checked >= 80) begin
        held       = 1'b1;
        stall_left = LONG_HOLD;
      end
      if (stall_left > 0) begin
        nxt = 1'b0;
        stall_left--;
      end else begin
        nxt = 1'b1;
        if ((rx_cyc % 1000) >= 150) begin
          r = $urandom_range(0, 99);
          if (r < 10) stall_left = $urandom_range(1, 3);
          else if (r < 12) stall_left = $urandom_range(8, 40);
        end
      end
      rsp_ch.ready <= nxt;
    end
  end

  function automatic logic signed [KEY_W-1:0] pick_key();
    logic signed [KEY_W-1:0] k;
    case ($urandom_range(0, 5))
      0: k = KEY_LO;
      1: k = KEY_HI;
      2, 3: k = $signed($urandom_range(0, 12)) - 6;
      default: k = $urandom;
    endcase
    return k;
  endfunction

  function automatic logic [REC_W-1:0] pick_record();
    logic [REC_W-1:0] r;
    case ($urandom_range(0, 9))
      0: r = '0;
      1: r = REC_HI;
      default: r = REC_W'($urandom);
    endcase
    return r;
  endfunction

  function automatic int tx_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // called just after a falling edge; returns just after the falling edge past the beat
  task automatic send_beat(input logic [1:0] o, input logic signed [KEY_W-1:0] k,
                           input logic [REC_W-1:0] rn, input int gap);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid         <= 1'b1;
    req_ch.op            <= o;
    req_ch.item_key      <= k;
    req_ch.record_number <= rn;
    do @(posedge clk); while (!req_ch.ready);
    @(negedge clk);
  endtask

  task automatic wait_for_results();
    req_ch.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  initial begin : stim
    int         r;
    int         ins_w;
    logic [1:0] o;
    rst                  = 1'b1;
    tx_steady            = 1'b0;
    req_ch.valid         = 1'b0;
    req_ch.op            = OP_INSERT;
    req_ch.item_key      = '0;
    req_ch.record_number = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // empty page corner cases
    send_beat(OP_SEARCH, KEY_HI, '0, 0);
    send_beat(OP_POP, '0, '0, 0);
    send_beat(OP_SPLIT, '0, '0, 0);
    // fill the page with extremes and duplicate keys
    send_beat(OP_INSERT, '0, '0, 0);
    send_beat(OP_INSERT, KEY_HI, REC_HI, 0);
    send_beat(OP_INSERT, KEY_LO, 31'd1, 0);
    send_beat(OP_INSERT, '0, 31'd5, 0);
    send_beat(OP_INSERT, -32'sd1, REC_HI, 0);
    send_beat(OP_INSERT, KEY_HI, 31'd2, 0);
    send_beat(OP_INSERT, 32'sd1, 31'h2AAA_AAAA, 0);
    send_beat(OP_INSERT, 32'sd3, 31'h5555_5555, 0);
    send_beat(OP_SEARCH, '0, '0, 0);
    send_beat(OP_SEARCH, 32'sd2, '0, 0);
    send_beat(OP_SEARCH, KEY_LO, '0, 0);
    send_beat(OP_POP, '0, '0, 0);
    send_beat(OP_INSERT, KEY_LO, REC_HI, 0);
    // split of a full page, then drain the kept half
    send_beat(OP_SPLIT, '0, '0, 0);
    send_beat(OP_POP, '0, '0, 0);
    send_beat(OP_POP, '0, '0, 0);
    send_beat(OP_POP, '0, '0, 0);
    send_beat(OP_INSERT, -32'sd5, 31'd9, 0);
    send_beat(OP_SPLIT, '0, '0, 0);
    send_beat(OP_SEARCH, -32'sd5, '0, 0);
    wait_for_results();

    // alternate fill-heavy and drain-heavy segments
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      ins_w     = (seg % 2 == 0) ? 55 : 25;
      tx_steady = (seg == 3);
      for (int i = 0; i < SEG_ITEMS; i++) begin
        r = $urandom_range(0, 99);
        if (r < ins_w) o = OP_INSERT;
        else if (r < ins_w + (100 - ins_w) / 2) o = OP_SEARCH;
        else if (r < 92) o = OP_POP;
        else o = OP_SPLIT;
        send_beat(o, pick_key(), pick_record(), tx_steady ? 0 : tx_gap());
      end
      if (seg % 2 == 1) wait_for_results();
    end
    wait_for_results();
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("Run covered %0d inserts, %0d searches, %0d pops and %0d splits",
             n_insert, n_search, n_pop, n_split);
    $display("on pages from empty to full; %0d result beats compared, %0d bad",
             beats_checked, err_count);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
